FILE: rtl/lpc_pkg.sv
// shared constants and types for the lru page cache
package lpc_pkg;

   localparam int PAGE_W   = 8;
   localparam int CAP_W    = 5;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 2;
   localparam int PAGE_SPAN = 2 ** PAGE_W;

   localparam int DEF_NUM_PAGES    = 256;
   localparam int DEF_MAX_CAPACITY = 16;

   localparam logic [ADDR_W-1:0] REG_CAPACITY   = 2'd0;
   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

   // request to the recency stack for the item under lookup
   typedef struct packed {
      logic              commit;
      logic              hit;
      logic [PAGE_W-1:0] key;
   } lpc_upd_type;

   // eviction decision from the recency stack
   typedef struct packed {
      logic              evict;
      logic [PAGE_W-1:0] victim;
   } lpc_evict_type;

endpackage

FILE: rtl/lpc_csr.sv
// capacity register behind the configuration port
module lpc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lpc_pkg::ADDR_W-1:0]  paddr,
   input  logic [lpc_pkg::DATA_W-1:0]  pwdata,
   output logic [lpc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output logic [lpc_pkg::CAP_W-1:0]   capacity
);

   logic [lpc_pkg::CAP_W-1:0] capacity_ff;
   logic                      wr_capacity;

   assign pready      = 1'b1;
   assign wr_capacity = psel && penable && pwrite && (paddr == lpc_pkg::REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lpc_pkg::CAPACITY_RESET;
      end else if (wr_capacity) begin
         capacity_ff <= pwdata[lpc_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == lpc_pkg::REG_CAPACITY) begin
         prdata = lpc_pkg::DATA_W'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

FILE: rtl/lpc_resident_map.sv
// one-bit residency memory with a clearing pass after reset
module lpc_resident_map #(
   parameter int NUM_PAGES = lpc_pkg::DEF_NUM_PAGES,
   localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic          rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic          wr_data,
   output logic          busy
);

   logic          mem [NUM_PAGES];
   logic          rd_data_ff;
   logic          busy_ff;
   logic [IW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == IW'(NUM_PAGES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

FILE: rtl/lpc_recency_stack.sv
// recency stack of resident pages, most recent at entry 0, plus occupancy
module lpc_recency_stack #(
   parameter int MAX_CAPACITY = lpc_pkg::DEF_MAX_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lpc_pkg::CAP_W-1:0] capacity,
   input  lpc_pkg::lpc_upd_type      upd,
   output lpc_pkg::lpc_evict_type    evict_info
);

   localparam int OW  = $clog2(MAX_CAPACITY + 1);
   localparam int PSW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int CW  = (OW > lpc_pkg::CAP_W) ? OW : lpc_pkg::CAP_W;

   logic [lpc_pkg::PAGE_W-1:0] stack_ff [MAX_CAPACITY];
   logic [lpc_pkg::PAGE_W-1:0] stack_in [MAX_CAPACITY];
   logic [OW-1:0]              occ_ff;
   logic [OW-1:0]              occ_in;
   logic [PSW-1:0]             pos;
   logic [OW-1:0]              depth;
   logic [CW-1:0]              occ_w;
   logic [CW-1:0]              cap_nz;
   logic                       full;
   logic                       evict;

   // pages are unique in the stack, so the matches can be or-ed together
   always_comb begin
      pos = '0;
      for (int i = 0; i < MAX_CAPACITY; i++) begin
         if ((OW'(i) < occ_ff) && (stack_ff[i] == upd.key)) begin
            pos = pos | PSW'(i);
         end
      end
   end

   always_comb begin
      occ_w  = CW'(occ_ff);
      cap_nz = (capacity == '0) ? CW'(1) : CW'(capacity);
      full   = (occ_w >= CW'(MAX_CAPACITY)) || (occ_w >= cap_nz);
      evict  = !upd.hit && (occ_ff != '0) && full;
   end

   assign evict_info.evict  = evict;
   assign evict_info.victim = stack_ff[PSW'(occ_ff - 1'b1)];

   always_comb begin
      if (upd.hit) begin
         depth = OW'(pos);
      end else if (evict) begin
         depth = occ_ff - 1'b1;
      end else begin
         depth = occ_ff;
      end
   end

   always_comb begin
      stack_in[0] = upd.key;
      for (int i = 1; i < MAX_CAPACITY; i++) begin
         stack_in[i] = (OW'(i) <= depth) ? stack_ff[i-1] : stack_ff[i];
      end
      occ_in = occ_ff;
      if (!upd.hit && !evict) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (upd.commit) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.commit) begin
         for (int i = 0; i < MAX_CAPACITY; i++) begin
            stack_ff[i] <= stack_in[i];
         end
      end
   end

endmodule

FILE: rtl/lru_page_cache.sv
// lru page cache: one result per request; each request takes a map read, then an update
// a new request is taken only in idle; the map read and the stack update serialize
// result appears the cycle after the lookup commits, held until the consumer takes it
// a pending victim clear is written to the map while the next request is taken
// synchronous reset; after reset a clearing pass over all NUM_PAGES map entries holds req_stall high
module lru_page_cache #(
   parameter int NUM_PAGES    = lpc_pkg::DEF_NUM_PAGES,
   parameter int MAX_CAPACITY = lpc_pkg::DEF_MAX_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lpc_pkg::PAGE_W-1:0]   req_page_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   output logic [lpc_pkg::PAGE_W-1:0]   rsp_evicted_page,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lpc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lpc_pkg::DATA_W-1:0]   pwdata,
   output logic [lpc_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_type;

   state_type                  state_ff;
   logic [IW-1:0]              idx_ff;
   logic [lpc_pkg::PAGE_W-1:0] key_ff;
   logic                       fwd_ff;
   logic                       clr_pending_ff;
   logic [IW-1:0]              clr_idx_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_evicted_ff;
   logic [lpc_pkg::PAGE_W-1:0] rsp_evicted_page_ff;

   logic [IW-1:0]              page_mod_table [lpc_pkg::PAGE_SPAN];
   logic [IW-1:0]              req_idx;
   logic [lpc_pkg::CAP_W-1:0]  capacity;
   logic                       accept;
   logic                       out_free;
   logic                       commit;
   logic                       hit;
   logic                       map_rd_data;
   logic                       map_busy;
   logic                       map_wr_en;
   logic [IW-1:0]              map_wr_addr;
   logic                       map_wr_data;
   lpc_pkg::lpc_upd_type       upd;
   lpc_pkg::lpc_evict_type     evict_info;

   // page number reduced modulo NUM_PAGES
   for (genvar g = 0; g < lpc_pkg::PAGE_SPAN; g++) begin : g_mod
      localparam int unsigned MODV = g % NUM_PAGES;
      assign page_mod_table[g] = IW'(MODV);
   end

   assign req_idx   = page_mod_table[req_page_number];
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_LOOKUP) && out_free;
   assign hit       = map_rd_data && !fwd_ff;

   assign upd.commit = commit;
   assign upd.hit    = hit;
   assign upd.key    = key_ff;

   lpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // a miss sets its own page now; the victim clear follows in the next cycle
   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = idx_ff;
      map_wr_data = 1'b1;
      if (commit && !hit) begin
         map_wr_en = 1'b1;
      end else if (clr_pending_ff) begin
         map_wr_en   = 1'b1;
         map_wr_addr = clr_idx_ff;
         map_wr_data = 1'b0;
      end
   end

   lpc_resident_map #(
      .NUM_PAGES (NUM_PAGES)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .busy    (map_busy)
   );

   lpc_recency_stack #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity),
      .upd        (upd),
      .evict_info (evict_info)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (!map_busy) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
            end
         endcase

         if (commit) begin
            clr_pending_ff <= evict_info.evict;
         end else if (clr_pending_ff) begin
            clr_pending_ff <= 1'b0;
         end

         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         idx_ff <= req_idx;
         key_ff <= lpc_pkg::PAGE_W'(req_idx);
         // the map read sees the page before its pending clear lands
         fwd_ff <= clr_pending_ff && (req_idx == clr_idx_ff);
      end
      if (commit) begin
         clr_idx_ff          <= IW'(evict_info.victim);
         rsp_hit_ff          <= hit;
         rsp_evicted_ff      <= evict_info.evict;
         rsp_evicted_page_ff <= evict_info.evict ? evict_info.victim : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_evicted_ff)
      else $error("result reports both a hit and an eviction");

   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      accept |-> !map_busy)
      else $error("request transfer during map clearing pass");

   a_result_from_lookup : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOOKUP))
      else $error("result raised without a lookup");

   a_clear_then_idle : assert property (@(posedge clock) disable iff (reset)
      clr_pending_ff |-> state_ff == S_IDLE)
      else $error("victim clear pending outside idle");

endmodule
